FILE: rtl/gql_pkg.sv
// gql_pkg: shared types and constants for the glyph quad layout block.
// Holds request/result structs, configuration struct, divider handshake
// structs and the fixed codes. No dependencies.
package gql_pkg;

  // Input request modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_LOAD = 2'd1;
  localparam logic [1:0] MODE_END  = 2'd2;

  // Result kinds
  localparam logic KIND_VERTEX  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Character codes with special handling
  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE   = 8'd32;

  // Corner order of one quad, bit k belongs to vertex k
  localparam int unsigned VTX_PER_QUAD = 6;
  localparam logic [VTX_PER_QUAD-1:0] CORNER_X = 6'b011010;
  localparam logic [VTX_PER_QUAD-1:0] CORNER_Y = 6'b110100;

  // Configuration register map (index = byte address / 4)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [2:0] REG_SHEET_COLS  = 3'd0;
  localparam logic [2:0] REG_SHEET_ROWS  = 3'd1;
  localparam logic [2:0] REG_GLYPH_W     = 3'd2;
  localparam logic [2:0] REG_GLYPH_H     = 3'd3;
  localparam logic [2:0] REG_FIRST_CODE  = 3'd4;
  localparam logic [2:0] REG_ADVANCE_GAP = 3'd5;

  // Register reset values
  localparam logic [6:0] RST_SHEET_COLS  = 7'd16;
  localparam logic [6:0] RST_SHEET_ROWS  = 7'd16;
  localparam logic [7:0] RST_GLYPH_W     = 8'd8;
  localparam logic [7:0] RST_GLYPH_H     = 8'd8;
  localparam logic [7:0] RST_FIRST_CODE  = 8'd32;
  localparam logic [7:0] RST_ADVANCE_GAP = 8'd1;

  // Shared divider sizing: numerator up to 127 << 16, 7-bit divisor
  localparam int unsigned DIV_NUM_W = 24;
  localparam int unsigned DIV_DEN_W = 7;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_NUM_W);

  typedef struct packed {
    logic [6:0] sheet_cols;
    logic [6:0] sheet_rows;
    logic [7:0] glyph_w;
    logic [7:0] glyph_h;
    logic [7:0] first_code;
    logic [7:0] advance_gap;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        char_code;
    logic [7:0]        glyph_index;
    logic signed [7:0] glyph_width;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] x_pos;
    logic [15:0]        y_pos;
    logic [16:0]        tex_u;
    logic [16:0]        tex_v;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

endpackage

FILE: rtl/gql_ram.sv
// gql_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing; storage has no reset.
module gql_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port; read data holds between reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/gql_div.sv
// gql_div: shared restoring divider, one quotient bit per cycle.
// Depends on gql_pkg for the numerator/divisor widths and handshake structs.
module gql_div (
  input  logic              clk,
  input  logic              rst_n,
  input  gql_pkg::div_req_t req,
  output gql_pkg::div_rsp_t rsp
);

  localparam int unsigned NW = gql_pkg::DIV_NUM_W;
  localparam int unsigned DW = gql_pkg::DIV_DEN_W;
  localparam int unsigned CW = gql_pkg::DIV_CNT_W;
  localparam logic [CW-1:0] CNT_LAST = CW'(NW - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [DW:0]   trial;
  logic          fits;

  // One restoring step: shift in the next numerator bit, subtract if it fits
  assign trial = {rem_r, num_r[NW-1]};
  assign fits  = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = req.num;
      quo_nxt  = '0;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      num_nxt = {num_r[NW-2:0], 1'b0};
      quo_nxt = {quo_r[NW-2:0], fits};
      rem_nxt = fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control under reset; operands need none
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

FILE: rtl/gql_cfg_regs.sv
// gql_cfg_regs: APB-style configuration registers of the layout block.
// Depends on gql_pkg for the register map, reset values and cfg_t.
module gql_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gql_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [gql_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [gql_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready,
  output gql_pkg::cfg_t                       cfg
);

  gql_pkg::cfg_t cfg_r, cfg_nxt;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Decode a write; unknown indexes drop
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (reg_idx)
        gql_pkg::REG_SHEET_COLS:  cfg_nxt.sheet_cols  = pwdata[6:0];
        gql_pkg::REG_SHEET_ROWS:  cfg_nxt.sheet_rows  = pwdata[6:0];
        gql_pkg::REG_GLYPH_W:     cfg_nxt.glyph_w     = pwdata[7:0];
        gql_pkg::REG_GLYPH_H:     cfg_nxt.glyph_h     = pwdata[7:0];
        gql_pkg::REG_FIRST_CODE:  cfg_nxt.first_code  = pwdata[7:0];
        gql_pkg::REG_ADVANCE_GAP: cfg_nxt.advance_gap = pwdata[7:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sheet_cols  <= gql_pkg::RST_SHEET_COLS;
      cfg_r.sheet_rows  <= gql_pkg::RST_SHEET_ROWS;
      cfg_r.glyph_w     <= gql_pkg::RST_GLYPH_W;
      cfg_r.glyph_h     <= gql_pkg::RST_GLYPH_H;
      cfg_r.first_code  <= gql_pkg::RST_FIRST_CODE;
      cfg_r.advance_gap <= gql_pkg::RST_ADVANCE_GAP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_idx)
      gql_pkg::REG_SHEET_COLS:  prdata = gql_pkg::CFG_DATA_W'(cfg_r.sheet_cols);
      gql_pkg::REG_SHEET_ROWS:  prdata = gql_pkg::CFG_DATA_W'(cfg_r.sheet_rows);
      gql_pkg::REG_GLYPH_W:     prdata = gql_pkg::CFG_DATA_W'(cfg_r.glyph_w);
      gql_pkg::REG_GLYPH_H:     prdata = gql_pkg::CFG_DATA_W'(cfg_r.glyph_h);
      gql_pkg::REG_FIRST_CODE:  prdata = gql_pkg::CFG_DATA_W'(cfg_r.first_code);
      gql_pkg::REG_ADVANCE_GAP: prdata = gql_pkg::CFG_DATA_W'(cfg_r.advance_gap);
      default:                  prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/glyph_quad_layout_core.sv
// glyph_quad_layout_core: top level of the sprite-sheet text layout block.
// Depends on gql_pkg, gql_cfg_regs, gql_div (shared divider) and gql_ram.
//
//  Channel   Direction  Handshake             Payload
//  in_       request    in_valid / in_stall   gql_pkg::in_item_t
//  out_      result     out_valid / out_stall gql_pkg::out_item_t
//  config    APB write  psel/penable/pwrite   paddr, pwdata, prdata
//
// A glyph in the sheet runs five 24-step divisions in the shared divider
// (column/row split, then two u and two v coordinates), then emits its six
// vertices. Other requests are handled without the divider.
// Reset is synchronous (rst_n low): pen, sequencer and output valid clear; the
// width table is not cleared. A stalled output holds the sequencer in an emit or summary state,
// and in_stall stays high until the current request is fully handled.
module glyph_quad_layout_core #(
  parameter int MAX_GLYPHS = 256,
  parameter int POS_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  gql_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output gql_pkg::out_item_t             out_data,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gql_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [gql_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [gql_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int AW = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
  localparam int SW = ((POS_BITS > 11) ? POS_BITS : 11) + 2;
  localparam int YW = ((POS_BITS > 8) ? POS_BITS : 8) + 1;
  localparam logic signed [SW-1:0] X_HI = SW'((longint'(1) <<< (POS_BITS - 1)) - longint'(1));
  localparam logic signed [SW-1:0] X_LO = ~X_HI;
  localparam logic [YW-1:0] Y_HI = YW'((longint'(1) << POS_BITS) - longint'(1));

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_DIV_GO, S_DIV_WAIT, S_EMIT, S_SUMMARY
  } state_t;

  typedef enum logic [2:0] {
    STEP_IDX, STEP_U0, STEP_U1, STEP_V0, STEP_V1
  } div_step_t;

  // Saturate to the signed pen range
  function automatic logic signed [POS_BITS-1:0] sat_x(input logic signed [SW-1:0] v);
    logic signed [POS_BITS-1:0] r;
    if (v > X_HI) begin
      r = X_HI[POS_BITS-1:0];
    end else if (v < X_LO) begin
      r = X_LO[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  // Saturate to the unsigned pen range
  function automatic logic [POS_BITS-1:0] sat_y(input logic [YW-1:0] v);
    logic [POS_BITS-1:0] r;
    if (v > Y_HI) begin
      r = Y_HI[POS_BITS-1:0];
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  gql_pkg::cfg_t      cfg;
  gql_pkg::div_req_t  div_req;
  gql_pkg::div_rsp_t  div_rsp;

  state_t                     state_r, state_nxt;
  div_step_t                  step_r, step_nxt;
  gql_pkg::in_item_t          item_r, item_nxt;
  logic [6:0]                 col_r, col_nxt;
  logic [6:0]                 row_r, row_nxt;
  logic [16:0]                u0_r, u0_nxt, u1_r, u1_nxt;
  logic [16:0]                v0_r, v0_nxt, v1_r, v1_nxt;
  logic [2:0]                 vtx_r, vtx_nxt;
  logic signed [POS_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [POS_BITS-1:0]        pen_y_r, pen_y_nxt;
  logic                       out_valid_r, out_valid_nxt;
  gql_pkg::out_item_t         out_data_r, out_data_nxt;

  logic [6:0]          cols_eff, rows_eff;
  logic [13:0]         glyph_cnt;
  logic [7:0]          idx;
  logic                glyph_ok;
  logic                load_ok;
  logic                ram_wr, ram_rd;
  logic [7:0]          ram_rdata;
  logic                out_free;
  logic                cx, cy;
  logic [9:0]          gap3;
  logic signed [SW-1:0] pen_x_ext, gap_ext, gap3_ext, width_ext, cw_ext;
  logic [YW-1:0]       pen_y_ext, ch_ext;
  logic signed [POS_BITS-1:0] vx;
  logic [POS_BITS-1:0] vy;

  gql_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gql_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  gql_ram #(
    .WIDTH (8),
    .DEPTH (MAX_GLYPHS)
  ) u_width_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (AW'(item_r.glyph_index)),
    .wr_data (item_r.glyph_width),
    .rd_en   (ram_rd),
    .rd_addr (AW'(idx)),
    .rd_data (ram_rdata)
  );

  // Sheet geometry and glyph range check; a zero count acts as one
  assign cols_eff  = (cfg.sheet_cols == '0) ? 7'd1 : cfg.sheet_cols;
  assign rows_eff  = (cfg.sheet_rows == '0) ? 7'd1 : cfg.sheet_rows;
  assign glyph_cnt = 14'(cols_eff) * 14'(rows_eff);
  assign idx       = item_r.char_code - cfg.first_code;
  assign glyph_ok  = (item_r.char_code >= cfg.first_code) && (14'(idx) < glyph_cnt) &&
                     (32'(idx) < MAX_GLYPHS);
  assign load_ok   = (32'(item_r.glyph_index) < MAX_GLYPHS);

  // Pen arithmetic operands
  assign cx        = gql_pkg::CORNER_X[vtx_r];
  assign cy        = gql_pkg::CORNER_Y[vtx_r];
  assign gap3      = {1'b0, cfg.advance_gap, 1'b0} + {2'b00, cfg.advance_gap};
  assign pen_x_ext = SW'(pen_x_r);
  assign gap_ext   = SW'(signed'({1'b0, cfg.advance_gap}));
  assign gap3_ext  = SW'(signed'({1'b0, gap3}));
  assign width_ext = SW'(signed'(ram_rdata));
  assign cw_ext    = cx ? SW'(signed'({1'b0, cfg.glyph_w})) : '0;
  assign pen_y_ext = YW'(pen_y_r);
  assign ch_ext    = cy ? YW'(cfg.glyph_h) : '0;
  assign vx        = sat_x(pen_x_ext + cw_ext);
  assign vy        = sat_y(pen_y_ext + ch_ext);

  assign out_free  = !out_valid_r || !out_stall;

  // Sequencer: decode, then five divisions and emit for a sheet glyph, or a summary for an end
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    item_nxt      = item_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    u0_nxt        = u0_r;
    u1_nxt        = u1_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    vtx_nxt       = vtx_r;
    pen_x_nxt     = pen_x_r;
    pen_y_nxt     = pen_y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ram_wr        = 1'b0;
    ram_rd        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = cols_eff;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_IDLE;
        case (item_r.mode)
          gql_pkg::MODE_LOAD: begin
            ram_wr = load_ok;
          end
          gql_pkg::MODE_END: begin
            state_nxt = S_SUMMARY;
          end
          gql_pkg::MODE_CHAR: begin
            if (item_r.char_code == gql_pkg::CHAR_SPACE) begin
              pen_x_nxt = sat_x(pen_x_ext + gap3_ext);
            end else if (item_r.char_code == gql_pkg::CHAR_NEWLINE) begin
              pen_y_nxt = sat_y(pen_y_ext + YW'(cfg.glyph_h));
              pen_x_nxt = '0;
            end else if (glyph_ok) begin
              ram_rd    = 1'b1;
              step_nxt  = STEP_IDX;
              state_nxt = S_DIV_GO;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end

      S_DIV_GO: begin
        div_req.start = 1'b1;
        case (step_r)
          STEP_IDX: div_req.num = gql_pkg::DIV_NUM_W'(idx);
          STEP_U0:  div_req.num = gql_pkg::DIV_NUM_W'({col_r, 16'h0000});
          STEP_U1:  div_req.num = gql_pkg::DIV_NUM_W'({8'(col_r) + 8'd1, 16'h0000});
          STEP_V0: begin
            div_req.num = gql_pkg::DIV_NUM_W'({row_r, 16'h0000});
            div_req.den = rows_eff;
          end
          STEP_V1: begin
            div_req.num = gql_pkg::DIV_NUM_W'({8'(row_r) + 8'd1, 16'h0000});
            div_req.den = rows_eff;
          end
          default: div_req.num = '0;
        endcase
        state_nxt = S_DIV_WAIT;
      end

      S_DIV_WAIT: begin
        if (div_rsp.done) begin
          state_nxt = S_DIV_GO;
          case (step_r)
            STEP_IDX: begin
              col_nxt  = div_rsp.rem;
              row_nxt  = div_rsp.quo[6:0];
              step_nxt = STEP_U0;
            end
            STEP_U0: begin
              u0_nxt   = div_rsp.quo[16:0];
              step_nxt = STEP_U1;
            end
            STEP_U1: begin
              u1_nxt   = div_rsp.quo[16:0];
              step_nxt = STEP_V0;
            end
            STEP_V0: begin
              v0_nxt   = div_rsp.quo[16:0];
              step_nxt = STEP_V1;
            end
            STEP_V1: begin
              v1_nxt    = div_rsp.quo[16:0];
              vtx_nxt   = '0;
              state_nxt = S_EMIT;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.kind  = gql_pkg::KIND_VERTEX;
          out_data_nxt.x_pos = 16'(vx);
          out_data_nxt.y_pos = 16'(vy);
          out_data_nxt.tex_u = cx ? u1_r : u0_r;
          out_data_nxt.tex_v = cy ? v1_r : v0_r;
          out_data_nxt.last  = (vtx_r == 3'(gql_pkg::VTX_PER_QUAD - 1));
          vtx_nxt            = vtx_r + 3'd1;
          // Advance the pen after the final corner
          if (vtx_r == 3'(gql_pkg::VTX_PER_QUAD - 1)) begin
            pen_x_nxt = sat_x(pen_x_ext + gap_ext + width_ext);
            state_nxt = S_IDLE;
          end
        end
      end

      S_SUMMARY: begin
        if (out_free) begin
          out_valid_nxt      = 1'b1;
          out_data_nxt.kind  = gql_pkg::KIND_SUMMARY;
          out_data_nxt.x_pos = 16'(pen_x_r);
          out_data_nxt.y_pos = 16'(cfg.glyph_h);
          out_data_nxt.tex_u = '0;
          out_data_nxt.tex_v = '0;
          out_data_nxt.last  = 1'b1;
          pen_x_nxt          = '0;
          pen_y_nxt          = '0;
          state_nxt          = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // State, pen and output register; payload registers take no reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= STEP_IDX;
      vtx_r       <= '0;
      pen_x_r     <= '0;
      pen_y_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      vtx_r       <= vtx_nxt;
      pen_x_r     <= pen_x_nxt;
      pen_y_r     <= pen_y_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r     <= item_nxt;
    col_r      <= col_nxt;
    row_r      <= row_nxt;
    u0_r       <= u0_nxt;
    u1_r       <= u1_nxt;
    v0_r       <= v0_nxt;
    v1_r       <= v1_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_vtx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (vtx_r < 3'(gql_pkg::VTX_PER_QUAD)))
    else $error("vertex counter out of range");

  a_summary_clears_pen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUMMARY && out_free) |=> (pen_x_r == '0 && pen_y_r == '0))
    else $error("pen not cleared after summary");

  a_tex_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.tex_u <= 17'h10000 && out_data_r.tex_v <= 17'h10000))
    else $error("texture coordinate above 1.0");

  a_summary_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == gql_pkg::KIND_SUMMARY) |->
      (out_data_r.last && out_data_r.tex_u == '0 && out_data_r.tex_v == '0))
    else $error("malformed summary result");
`endif

endmodule

FILE: sim/tb_top.sv
// Self-checking bench for glyph_quad_layout_core: text requests in, quad vertices out.
// Needs gql_pkg and the layout RTL. A built-in layout predictor supplies the
// expected vertices and end-of-string summaries, which are checked in order.
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int TABLE_DEPTH     = 256;
  localparam int SETTLE_CYCLES   = 160;   // longer than one glyph
  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int RANDOM_REQUESTS = 170;
  localparam int IDLE_PERCENT    = 11;
  localparam int MAX_REPORTS     = 10;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  gql_pkg::in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      psel      = 1'b0;
  logic      penable   = 1'b0;
  logic      pwrite    = 1'b0;
  logic [gql_pkg::CFG_ADDR_W-1:0] paddr  = '0;
  logic [gql_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic      in_stall;
  logic      out_valid;
  gql_pkg::out_item_t out_data;
  logic [gql_pkg::CFG_DATA_W-1:0] prdata;
  logic      pready;

  // Predictor state: pen, per-glyph advance table and the active sheet setting
  int        pen_x = 0;
  int        pen_y = 0;
  logic signed [7:0] advance_table [TABLE_DEPTH];
  bit        advance_known [TABLE_DEPTH];
  gql_pkg::cfg_t sheet_cfg = '{gql_pkg::RST_SHEET_COLS, gql_pkg::RST_SHEET_ROWS,
                               gql_pkg::RST_GLYPH_W, gql_pkg::RST_GLYPH_H,
                               gql_pkg::RST_FIRST_CODE, gql_pkg::RST_ADVANCE_GAP};
  gql_pkg::out_item_t layout_q [$];

  int        error_count      = 0;
  int        requests_sent    = 0;
  int        results_seen     = 0;
  int        settings_applied = 0;
  bit        no_idle          = 1'b0;

  glyph_quad_layout_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic void flag_error(string msg);
    if (error_count < MAX_REPORTS) $display("ERROR: %s", msg);
    error_count++;
  endfunction

  function automatic int clamp_x(int v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic int clamp_y(int v);
    return (v > 65535) ? 65535 : ((v < 0) ? 0 : v);
  endfunction

  // A zero column or row count behaves as one
  function automatic int eff_cols();
    return (sheet_cfg.sheet_cols == 0) ? 1 : int'(sheet_cfg.sheet_cols);
  endfunction

  function automatic int eff_rows();
    return (sheet_cfg.sheet_rows == 0) ? 1 : int'(sheet_cfg.sheet_rows);
  endfunction

  // True when the code maps to a glyph of the sheet; idx is its sheet index
  function automatic bit glyph_slot(logic [7:0] code, output int idx);
    idx = int'(code) - int'(sheet_cfg.first_code);
    return code != gql_pkg::CHAR_SPACE && code != gql_pkg::CHAR_NEWLINE && idx >= 0 &&
           idx < eff_cols() * eff_rows() && idx < TABLE_DEPTH;
  endfunction

  // Work out the results of one accepted request and advance the pen
  function automatic void layout_request(gql_pkg::in_item_t req);
    gql_pkg::out_item_t r;
    int idx, col, row, k, w, h, gap, extra;
    w   = int'(sheet_cfg.glyph_w);
    h   = int'(sheet_cfg.glyph_h);
    gap = int'(sheet_cfg.advance_gap);
    r   = '0;
    case (req.mode)
      gql_pkg::MODE_LOAD: begin
        advance_table[req.glyph_index] = req.glyph_width;
        advance_known[req.glyph_index] = 1'b1;
      end
      gql_pkg::MODE_END: begin
        r.kind  = gql_pkg::KIND_SUMMARY;
        r.x_pos = 16'(pen_x);
        r.y_pos = 16'(h);
        r.last  = 1'b1;
        layout_q.push_back(r);
        pen_x = 0;
        pen_y = 0;
      end
      gql_pkg::MODE_CHAR: begin
        if (req.char_code == gql_pkg::CHAR_SPACE) begin
          pen_x = clamp_x(pen_x + 3 * gap);
        end else if (req.char_code == gql_pkg::CHAR_NEWLINE) begin
          pen_y = clamp_y(pen_y + h);
          pen_x = 0;
        end else if (glyph_slot(req.char_code, idx)) begin
          col = idx % eff_cols();
          row = idx / eff_cols();
          for (k = 0; k < gql_pkg::VTX_PER_QUAD; k++) begin
            r.kind  = gql_pkg::KIND_VERTEX;
            r.x_pos = 16'(clamp_x(pen_x + (gql_pkg::CORNER_X[k] ? w : 0)));
            r.y_pos = 16'(clamp_y(pen_y + (gql_pkg::CORNER_Y[k] ? h : 0)));
            r.tex_u = 17'(((col + int'(gql_pkg::CORNER_X[k])) * 65536) / eff_cols());
            r.tex_v = 17'(((row + int'(gql_pkg::CORNER_Y[k])) * 65536) / eff_rows());
            r.last  = (k == gql_pkg::VTX_PER_QUAD - 1);
            layout_q.push_back(r);
          end
          extra = advance_table[idx];
          pen_x = clamp_x(pen_x + gap + extra);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic gql_pkg::in_item_t req_of(logic [1:0] m, logic [7:0] code,
                                               logic [7:0] gidx, logic [7:0] gwidth);
    gql_pkg::in_item_t r;
    r.mode        = m;
    r.char_code   = code;
    r.glyph_index = gidx;
    r.glyph_width = gwidth;
    return r;
  endfunction

  function automatic gql_pkg::cfg_t setting_of(int c, int r, int w, int h, int f, int g);
    gql_pkg::cfg_t s;
    s.sheet_cols  = 7'(c);
    s.sheet_rows  = 7'(r);
    s.glyph_w     = 8'(w);
    s.glyph_h     = 8'(h);
    s.first_code  = 8'(f);
    s.advance_gap = 8'(g);
    return s;
  endfunction

  // Present one request and hold it until taken; valid stays high on return
  task automatic push_request(gql_pkg::in_item_t req);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= req;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    layout_request(req);
  endtask

  // Load a width first when a glyph would read a table entry never written
  task automatic send_request(gql_pkg::in_item_t req);
    int idx;
    if (req.mode == gql_pkg::MODE_CHAR && glyph_slot(req.char_code, idx) &&
        !advance_known[idx])
      push_request(req_of(gql_pkg::MODE_LOAD, 8'($urandom), 8'(idx), 8'($urandom)));
    push_request(req);
  endtask

  task automatic send_char(logic [7:0] code);
    send_request(req_of(gql_pkg::MODE_CHAR, code, 8'($urandom), 8'($urandom)));
  endtask

  // Drop valid, drain every expected result, then let trailing requests finish
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (layout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one register, then read it back
  task automatic program_register(logic [2:0] idx, logic [gql_pkg::CFG_DATA_W-1:0] value);
    logic [gql_pkg::CFG_DATA_W-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== value)
      flag_error($sformatf("register %0d reads %0d, wrote %0d", idx, got, value));
  endtask

  task automatic apply_setting(gql_pkg::cfg_t s);
    settle_idle();
    program_register(gql_pkg::REG_SHEET_COLS, 32'(s.sheet_cols));
    program_register(gql_pkg::REG_SHEET_ROWS, 32'(s.sheet_rows));
    program_register(gql_pkg::REG_GLYPH_W, 32'(s.glyph_w));
    program_register(gql_pkg::REG_GLYPH_H, 32'(s.glyph_h));
    program_register(gql_pkg::REG_FIRST_CODE, 32'(s.first_code));
    program_register(gql_pkg::REG_ADVANCE_GAP, 32'(s.advance_gap));
    sheet_cfg = s;
    settings_applied++;
  endtask

  function automatic int draw_count7();
    case ($urandom_range(4))
      0:       return $urandom_range(1);
      1:       return 127;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic gql_pkg::cfg_t draw_setting();
    return setting_of(draw_count7(), draw_count7(), $urandom_range(255), $urandom_range(255),
                      ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(64),
                      ($urandom_range(4) == 0) ? 255 : $urandom_range(8));
  endfunction

  // Mostly glyphs of the current sheet, with spacing, loads, ends and noise
  function automatic gql_pkg::in_item_t draw_request();
    gql_pkg::in_item_t r;
    int pick, span;
    r = req_of(gql_pkg::MODE_CHAR, 8'($urandom), 8'($urandom), 8'($urandom));
    pick = $urandom_range(99);
    if (pick < 60) begin
      span = eff_cols() * eff_rows();
      if (span > TABLE_DEPTH) span = TABLE_DEPTH;
      if (span > 256 - int'(sheet_cfg.first_code)) span = 256 - int'(sheet_cfg.first_code);
      r.char_code = 8'(int'(sheet_cfg.first_code) + $urandom_range(span - 1));
    end else if (pick < 70) begin
      r.char_code = gql_pkg::CHAR_SPACE;
    end else if (pick < 76) begin
      r.char_code = gql_pkg::CHAR_NEWLINE;
    end else if (pick < 84) begin
      r.mode = gql_pkg::MODE_LOAD;
    end else if (pick < 90) begin
      r.mode = gql_pkg::MODE_END;
    end else if (pick >= 97) begin
      r.mode = MODE_UNUSED;
    end
    return r;
  endfunction

  // Extremes of every field and each request type under the reset sheet
  task automatic test_basic_text();
    send_request(req_of(MODE_UNUSED, 8'hFF, 8'hFF, 8'hFF));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'h00, 8'd255, 8'h80));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'hFF, 8'd0, 8'h55));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'h00, 8'd1, 8'h7F));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'h00, 8'd223, 8'hFF));
    send_char(8'd33);
    send_char(8'd0);
    send_char(8'd31);
    send_char(gql_pkg::CHAR_SPACE);
    send_char(8'd255);
    send_char(gql_pkg::CHAR_NEWLINE);
    send_char(8'd126);
    send_char(8'd127);
    send_request(req_of(gql_pkg::MODE_END, 8'hAA, 8'h55, 8'hAA));
    send_request(req_of(gql_pkg::MODE_END, 8'h55, 8'hAA, 8'h55));
    send_char(gql_pkg::CHAR_SPACE);
    send_char(gql_pkg::CHAR_SPACE);
    send_request(req_of(gql_pkg::MODE_END, 8'h00, 8'h00, 8'h00));
    send_char(gql_pkg::CHAR_NEWLINE);
    send_char(8'd64);
    send_request(req_of(gql_pkg::MODE_END, 8'hFF, 8'hFF, 8'hFF));
  endtask

  // Sheet edges: first glyph, last glyph, one past each end, under corner settings
  task automatic test_sheet_settings();
    gql_pkg::cfg_t corners [5];
    int n, lo, hi;
    corners[0] = setting_of(1, 1, 255, 255, 0, 255);
    corners[1] = setting_of(0, 0, 1, 1, 255, 0);
    corners[2] = setting_of(127, 127, 0, 0, 0, 7);
    corners[3] = setting_of(64, 64, 17, 9, 48, 3);
    corners[4] = setting_of(7, 3, 200, 100, 65, 2);
    for (n = 0; n < 5; n++) begin
      apply_setting(corners[n]);
      lo = int'(sheet_cfg.first_code);
      hi = lo + eff_cols() * eff_rows() - 1;
      send_char(8'(lo));
      if (hi <= 255) send_char(8'(hi));
      if (hi < 255) send_char(8'(hi + 1));
      if (lo > 0) send_char(8'(lo - 1));
      send_char(gql_pkg::CHAR_NEWLINE);
      send_request(draw_request());
      send_request(draw_request());
      send_request(req_of(gql_pkg::MODE_END, 8'($urandom), 8'($urandom), 8'($urandom)));
    end
  endtask

  // Drive the pen into the upper x limit, then walk it to negative positions
  task automatic test_pen_saturation();
    apply_setting(setting_of(16, 16, 255, 255, 32, 255));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'h00, 8'd1, 8'h7F));
    repeat (44) send_char(gql_pkg::CHAR_SPACE);
    send_char(8'd33);
    repeat (2) send_char(gql_pkg::CHAR_SPACE);
    send_char(gql_pkg::CHAR_NEWLINE);
    send_char(8'd33);
    send_request(req_of(gql_pkg::MODE_END, 8'h00, 8'h00, 8'h00));
    apply_setting(setting_of(16, 16, 255, 255, 32, 0));
    send_request(req_of(gql_pkg::MODE_LOAD, 8'h00, 8'd1, 8'h80));
    repeat (8) send_char(8'd33);
    send_request(req_of(gql_pkg::MODE_END, 8'h00, 8'h00, 8'h00));
  endtask

  // Random text, a new sheet setting every 60 requests, one stretch without idling
  task automatic test_random_text();
    gql_pkg::in_item_t r;
    int counted, next_change;
    counted     = 0;
    next_change = 60;
    while (counted < RANDOM_REQUESTS) begin
      if (counted >= next_change) begin
        apply_setting(draw_setting());
        next_change += 60;
      end
      no_idle = (counted >= 50 && counted < 130);
      r = draw_request();
      send_request(r);
      if (r.mode != MODE_UNUSED) counted++;
    end
    no_idle = 1'b0;
  endtask

  // Check each taken result against the oldest expectation; stall at random
  always @(posedge clk) begin
    gql_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (layout_q.size() == 0) begin
        flag_error($sformatf("result with nothing pending: kind %0d x %0d y %0d",
                             out_data.kind, out_data.x_pos, out_data.y_pos));
      end else begin
        want = layout_q.pop_front();
        if (out_data.kind !== want.kind || out_data.x_pos !== want.x_pos ||
            out_data.y_pos !== want.y_pos || out_data.tex_u !== want.tex_u ||
            out_data.tex_v !== want.tex_v || out_data.last !== want.last)
          flag_error($sformatf({"exp kind %0d x %0d y %0d u %0d v %0d last %0d, ",
                                "got kind %0d x %0d y %0d u %0d v %0d last %0d"},
            want.kind, want.x_pos, want.y_pos, want.tex_u, want.tex_v, want.last,
            out_data.kind, out_data.x_pos, out_data.y_pos, out_data.tex_u,
            out_data.tex_v, out_data.last));
      end
    end
    out_stall <= (rst_n && !no_idle) ? ($urandom_range(99) < IDLE_PERCENT) : 1'b0;
  end

  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d results pending", layout_q.size());
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_basic_text();
    test_sheet_settings();
    test_pen_saturation();
    test_random_text();
    settle_idle();
    $display("covered %0d requests and %0d results over %0d sheet settings",
             requests_sent, results_seen, settings_applied);
    $display("including the upper pen x limit, negative pen x and out-of-sheet codes");
    if (error_count == 0 && layout_q.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
